// ===== design/soil_moisture_watering_decider_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef SOIL_MOISTURE_WATERING_DECIDER_MACROS_SVH
`define SOIL_MOISTURE_WATERING_DECIDER_MACROS_SVH

// Checked only outside reset.
`define SMWD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define SMWD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/smwd_pkg.sv =====
package smwd_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int TIME_W     = 32;
  localparam int PULSE_W    = 16;
  localparam int PCT_W      = 7;
  localparam int COUNT_W    = 32;
  localparam int SPAN_W     = SAMPLE_W + 1;
  // |sample - dry| * 100 fits in 17 bits
  localparam int MAP_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 64;
  localparam int PCT_MAX    = 100;

  localparam logic [SAMPLE_W-1:0] DRY_RESET   = 10'd600;
  localparam logic [SAMPLE_W-1:0] WET_RESET   = 10'd300;
  localparam logic [TIME_W-1:0]   PAUSE_RESET = 32'd3600000;
  localparam logic [SAMPLE_W-1:0] LIGHT_RESET = 10'd20;
  localparam logic [PCT_W-1:0]    MOIST_RESET = 7'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRY_READING    = 3'd0,
    REG_WET_READING    = 3'd1,
    REG_PAUSE_TICKS    = 3'd2,
    REG_LIGHT_LIMIT    = 3'd3,
    REG_MOISTURE_LIMIT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic load_in;
    logic map_go;
    logic write_win;
    logic avg_take;
    logic out_load;
  } smwd_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } smwd_sts_t;

endpackage

// ===== design/soil_moisture_watering_decider.sv =====
// Soil moisture watering decider. Each request is a moisture sample
// (s_tuser = 0) or a watering check (s_tuser = 1) and gives exactly one
// result. A sample is mapped from the dry/wet calibration span to a clamped
// percent and pushed into a WINDOW_DEPTH-entry window; a check orders
// watering when the pause has strictly passed, light is below its limit and
// the window average is below the moisture limit. One request is in work at a
// time. A sample goes from acceptance through capture, the start of the
// bit-serial calibration divider, its 17 quotient bits at one per cycle, the
// wait for it to finish, a window update, a reciprocal-multiply average and
// the output load. A check goes through capture, average and output load.
// A finished result sits in the output register, so the next request
// can be taken while it waits; a result still held there stalls the next one
// at its output load. Registers are to be written only while idle; the block
// itself does not enforce this.
module soil_moisture_watering_decider #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [smwd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smwd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // moisture_sample[9:0], light_sample[19:10], now_time[51:20],
  // pulse_request[67:52], zero fill
  input  logic [smwd_pkg::IN_DATA_W-1:0]    s_tdata,
  // mode
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // moisture_percent[6:0], average_percent[13:7], water_now[14],
  // pulse_length[30:15], watering_total[62:31], zero fill
  output logic [smwd_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import smwd_pkg::*;

  smwd_cmd_t cmd;
  smwd_sts_t sts;

  smwd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tuser (s_tuser),
    .s_tready(s_tready),
    .cmd     (cmd),
    .sts     (sts)
  );

  smwd_dp #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// ===== design/smwd_ram.sv =====
module smwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/smwd_div.sv =====
module smwd_div #(
  parameter int DIV_W = 17,
  parameter int DVS_W = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DIV_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DVS_W:0]   shifted;
  logic             ge;

  // restoring division, one quotient bit per cycle
  assign shifted  = {rem, quo[DIV_W-1]};
  assign ge       = shifted >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? DVS_W'(shifted - {1'b0, dvs}) : shifted[DVS_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

endmodule

// ===== design/smwd_ctrl.sv =====
module smwd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tuser,
  output logic                 s_tready,
  output smwd_pkg::smwd_cmd_t  cmd,
  input  smwd_pkg::smwd_sts_t  sts
);
  import smwd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_MAP_GO   = 6'b000010,
    S_MAP_WAIT = 6'b000100,
    S_WRITE    = 6'b001000,
    S_AVG      = 6'b010000,
    S_OUT      = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = s_tuser ? S_AVG : S_MAP_GO;
        end
      end
      S_MAP_GO: begin
        cmd.map_go = 1'b1;
        state_next = S_MAP_WAIT;
      end
      S_MAP_WAIT: begin
        if (sts.div_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_win = 1'b1;
        state_next    = S_AVG;
      end
      S_AVG: begin
        cmd.avg_take = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/smwd_dp.sv =====
module smwd_dp #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [smwd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smwd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [smwd_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [smwd_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  smwd_pkg::smwd_cmd_t                 cmd,
  output smwd_pkg::smwd_sts_t                 sts
);
  import smwd_pkg::*;

  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W = $clog2(PCT_MAX * WINDOW_DEPTH + 1);
  // average by reciprocal multiply, exact for every sum below 2**SUM_W
  localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW_DEPTH);
  localparam int AVG_MUL   = (2 ** AVG_SHIFT + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
  localparam int PROD_W    = 2 * SUM_W + 2;

  // configuration
  logic [SAMPLE_W-1:0] dry_reading;
  logic [SAMPLE_W-1:0] wet_reading;
  logic [TIME_W-1:0]   pause_ticks;
  logic [SAMPLE_W-1:0] light_limit;
  logic [PCT_W-1:0]    moisture_limit;

  // captured request
  logic                mode;
  logic [SAMPLE_W-1:0] moist;
  logic [SAMPLE_W-1:0] light;
  logic [TIME_W-1:0]   now_time;
  logic [PULSE_W-1:0]  pulse;

  // window and watering state
  logic [WINDOW_DEPTH-1:0] win_valid;
  logic [PTR_W-1:0]        win_ptr;
  logic [SUM_W-1:0]        win_sum;
  logic [TIME_W-1:0]       last_water_time;
  logic [COUNT_W-1:0]      water_count;
  logic [COUNT_W-1:0]      water_count_next;
  logic [PCT_W-1:0]        percent;
  logic [PCT_W-1:0]        average;
  logic                    map_zero;

  logic signed [SPAN_W-1:0] span;
  logic signed [SPAN_W-1:0] diff;
  logic [SPAN_W-1:0]        span_abs;
  logic [SPAN_W-1:0]        diff_abs;
  logic [MAP_W-1:0]         map_num;
  logic                     map_zero_c;

  logic                div_start;
  logic [MAP_W-1:0]    div_dividend;
  logic [SAMPLE_W-1:0] div_divisor;
  logic [MAP_W-1:0]    div_quo;
  logic                div_done;

  logic [PROD_W-1:0] avg_prod;
  logic [PCT_W-1:0]  avg_c;

  logic [PCT_W-1:0]  ram_rdata;
  logic [PCT_W-1:0]  old_pct;
  logic [PCT_W-1:0]  pct_c;
  logic              water_c;

  assign span     = $signed({1'b0, wet_reading}) - $signed({1'b0, dry_reading});
  assign diff     = $signed({1'b0, moist}) - $signed({1'b0, dry_reading});
  assign span_abs = span[SPAN_W-1] ? SPAN_W'(-span) : SPAN_W'(span);
  assign diff_abs = diff[SPAN_W-1] ? SPAN_W'(-diff) : SPAN_W'(diff);
  assign map_num  = MAP_W'(diff_abs[SAMPLE_W-1:0]) * MAP_W'(PCT_MAX);

  // opposite signs or a zero term truncate to a percent of at most zero
  assign map_zero_c = (span == '0) || (diff == '0) || (span[SPAN_W-1] != diff[SPAN_W-1]);

  assign div_start    = cmd.map_go;
  assign div_dividend = map_num;
  assign div_divisor  = span_abs[SAMPLE_W-1:0];

  smwd_div #(
    .DIV_W(MAP_W),
    .DVS_W(SAMPLE_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .quotient(div_quo),
    .done    (div_done)
  );

  smwd_ram #(
    .WIDTH(PCT_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk  (clk),
    .we   (cmd.write_win),
    .waddr(win_ptr),
    .wdata(pct_c),
    .raddr(win_ptr),
    .rdata(ram_rdata)
  );

  assign pct_c = map_zero ? '0 :
                 (div_quo >= MAP_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : div_quo[PCT_W-1:0];
  // unwritten slots count as zero, whatever the window RAM holds there
  assign old_pct = win_valid[win_ptr] ? ram_rdata : '0;

  assign avg_prod = PROD_W'(win_sum) * PROD_W'(AVG_MUL);
  assign avg_c    = avg_prod[AVG_SHIFT +: PCT_W];

  assign water_c = mode
                && ((now_time - last_water_time) > pause_ticks)
                && (light < light_limit)
                && (average < moisture_limit);
  assign water_count_next = water_c ? water_count + COUNT_W'(1) : water_count;

  assign sts.div_done = div_done;
  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dry_reading     <= DRY_RESET;
      wet_reading     <= WET_RESET;
      pause_ticks     <= PAUSE_RESET;
      light_limit     <= LIGHT_RESET;
      moisture_limit  <= MOIST_RESET;
      win_valid       <= '0;
      win_ptr         <= '0;
      win_sum         <= '0;
      last_water_time <= '0;
      water_count     <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_DRY_READING:    dry_reading    <= cfg_data[SAMPLE_W-1:0];
          REG_WET_READING:    wet_reading    <= cfg_data[SAMPLE_W-1:0];
          REG_PAUSE_TICKS:    pause_ticks    <= cfg_data[TIME_W-1:0];
          REG_LIGHT_LIMIT:    light_limit    <= cfg_data[SAMPLE_W-1:0];
          REG_MOISTURE_LIMIT: moisture_limit <= cfg_data[PCT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.write_win) begin
        win_valid[win_ptr] <= 1'b1;
        win_sum            <= win_sum - SUM_W'(old_pct) + SUM_W'(pct_c);
        win_ptr            <= (win_ptr == PTR_W'(WINDOW_DEPTH - 1)) ? '0
                                                                    : win_ptr + PTR_W'(1);
      end
      if (cmd.out_load) begin
        m_tvalid    <= 1'b1;
        water_count <= water_count_next;
        if (water_c) begin
          last_water_time <= now_time;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode     <= s_tuser;
      moist    <= s_tdata[9:0];
      light    <= s_tdata[19:10];
      now_time <= s_tdata[51:20];
      pulse    <= s_tdata[67:52];
      percent  <= '0;
    end
    if (cmd.map_go) begin
      map_zero <= map_zero_c;
    end
    if (cmd.write_win) begin
      percent <= pct_c;
    end
    if (cmd.avg_take) begin
      average <= avg_c;
    end
    if (cmd.out_load) begin
      m_tdata <= {1'b0, water_count_next, (water_c ? pulse : PULSE_W'(0)),
                  water_c, average, percent};
    end
  end

endmodule

// ===== design/smwd_checker.sv =====
`include "soil_moisture_watering_decider_macros.svh"

module smwd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  `SMWD_ASSERT_ALWAYS(a_no_result_after_reset, rst |=> !m_tvalid, "result valid after reset")

  // one request in work at a time
  `SMWD_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "request taken while busy")

  `SMWD_ASSERT(a_stall_holds, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

  `SMWD_ASSERT(a_pulse_needs_water, (m_tvalid && !m_tdata[14]) |-> (m_tdata[30:15] == 16'd0), "pulse without watering")

  `SMWD_ASSERT(a_percent_range, m_tvalid |-> ((m_tdata[6:0] <= 7'd100) && (m_tdata[13:7] <= 7'd100)), "percent out of range")

endmodule

bind soil_moisture_watering_decider smwd_checker u_smwd_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

// ===== tb/soil_moisture_watering_decider_tb.sv =====
`timescale 1ns / 1ps

module soil_moisture_watering_decider_tb;
  import smwd_pkg::*;

  localparam int WINDOW_DEPTH = 8;
  localparam int SETTLE_CYCLES = 50;
  localparam int IDLE_PCT = 23;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  typedef struct packed {
    logic [PCT_W-1:0]   moisture_pct;
    logic [PCT_W-1:0]   average_pct;
    logic               water_now;
    logic [PULSE_W-1:0] pulse_len;
    logic [COUNT_W-1:0] water_total;
  } decision_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // moisture_sample, light_sample, now_time, pulse_request, zero fill
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  // mode
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // moisture_percent, average_percent, water_now, pulse_length, watering_total
  logic [OUT_DATA_W-1:0] m_tdata;

  // predictor copy of the registers
  logic [SAMPLE_W-1:0] dry_cal;
  logic [SAMPLE_W-1:0] wet_cal;
  logic [TIME_W-1:0]   pause_min;
  logic [SAMPLE_W-1:0] light_max;
  logic [PCT_W-1:0]    moist_max;
  // predictor copy of the state
  logic [PCT_W-1:0]    pct_hist [WINDOW_DEPTH];
  int unsigned         hist_ptr;
  logic [9:0]          hist_sum;
  logic [TIME_W-1:0]   last_watered;
  logic [COUNT_W-1:0]  water_tally;

  decision_t pending_decisions[$];
  int err_count = 0;
  int n_samples = 0;
  int n_checks = 0;
  int n_watered = 0;
  int n_settings = 1;
  bit steady = 1'b0;
  bit tx_up = 1'b0;
  logic [TIME_W-1:0] sim_ticks = '0;

  soil_moisture_watering_decider #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic decision_t predict_decision(logic mode, logic [SAMPLE_W-1:0] moist,
                                                 logic [SAMPLE_W-1:0] light,
                                                 logic [TIME_W-1:0] now,
                                                 logic [PULSE_W-1:0] pulse);
    decision_t d;
    int num;
    int den;
    int q;
    logic [PCT_W-1:0] pct;
    logic [TIME_W-1:0] since;
    d = '0;
    if (mode == MODE_SAMPLE) begin
      den = int'(wet_cal) - int'(dry_cal);
      if (den == 0) begin
        pct = '0;
      end else begin
        num = (int'(moist) - int'(dry_cal)) * PCT_MAX;
        q = num / den;
        if (q >= PCT_MAX) pct = PCT_W'(PCT_MAX);
        else if (q <= 0) pct = '0;
        else pct = PCT_W'(q);
      end
      hist_sum = hist_sum - pct_hist[hist_ptr] + pct;
      pct_hist[hist_ptr] = pct;
      hist_ptr = (hist_ptr + 1) % WINDOW_DEPTH;
      d.moisture_pct = pct;
      d.average_pct = PCT_W'(hist_sum / WINDOW_DEPTH);
    end else begin
      d.average_pct = PCT_W'(hist_sum / WINDOW_DEPTH);
      since = now - last_watered;
      if (since > pause_min && light < light_max && d.average_pct < moist_max) begin
        water_tally = water_tally + 1'b1;
        last_watered = now;
        d.water_now = 1'b1;
        d.pulse_len = pulse;
      end
    end
    d.water_total = water_tally;
    return d;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    decision_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_decisions.size() == 0) begin
        err_count++;
        $display("%0t: result with nothing pending, expected none, actual %h",
                 $time, m_tdata);
      end else begin
        want = pending_decisions.pop_front();
        check_field("moisture_percent", want.moisture_pct, m_tdata[6:0]);
        check_field("average_percent", want.average_pct, m_tdata[13:7]);
        check_field("water_now", want.water_now, m_tdata[14]);
        check_field("pulse_length", want.pulse_len, m_tdata[30:15]);
        check_field("watering_total", want.water_total, m_tdata[62:31]);
        if (want.water_now) n_watered++;
      end
    end
  end

  // valid stays up between back-to-back requests; lowered only for a gap
  task automatic send_request(logic mode, logic [SAMPLE_W-1:0] moist,
                              logic [SAMPLE_W-1:0] light, logic [TIME_W-1:0] now,
                              logic [PULSE_W-1:0] pulse);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      if (tx_up) begin
        s_tvalid <= 1'b0;
        tx_up = 1'b0;
      end
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    tx_up = 1'b1;
    s_tuser <= mode;
    s_tdata <= {4'b0, pulse, now, light, moist};
    do @(posedge clk); while (!s_tready);
    pending_decisions.insert(pending_decisions.size(),
                             predict_decision(mode, moist, light, now, pulse));
    if (mode == MODE_SAMPLE) n_samples++;
    else n_checks++;
  endtask

  // hold off until every pending result is back and the block has gone quiet
  task automatic wait_idle();
    if (tx_up) begin
      s_tvalid <= 1'b0;
      tx_up = 1'b0;
    end
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_DRY_READING:    dry_cal = value[SAMPLE_W-1:0];
      REG_WET_READING:    wet_cal = value[SAMPLE_W-1:0];
      REG_PAUSE_TICKS:    pause_min = value[TIME_W-1:0];
      REG_LIGHT_LIMIT:    light_max = value[SAMPLE_W-1:0];
      REG_MOISTURE_LIMIT: moist_max = value[PCT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [CFG_DATA_W-1:0] dry, logic [CFG_DATA_W-1:0] wet,
                               logic [CFG_DATA_W-1:0] pause,
                               logic [CFG_DATA_W-1:0] light_lim,
                               logic [CFG_DATA_W-1:0] moist_lim);
    write_reg(REG_DRY_READING, dry);
    write_reg(REG_WET_READING, wet);
    write_reg(REG_PAUSE_TICKS, pause);
    write_reg(REG_LIGHT_LIMIT, light_lim);
    write_reg(REG_MOISTURE_LIMIT, moist_lim);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  // reset calibration, pause edges, light at its limit, clamp extremes
  task automatic test_defaults();
    send_request(MODE_CHECK, '0, '0, '0, '1);
    send_request(MODE_CHECK, '0, '0, 32'd3600001, '1);
    send_request(MODE_CHECK, '0, '0, 32'd7200001, 16'h1234);
    send_request(MODE_CHECK, '1, 10'd19, 32'd7200002, '0);
    send_request(MODE_CHECK, '0, 10'd20, '1, 16'h0005);
    send_request(MODE_SAMPLE, 10'd0, '0, '0, '0);
    send_request(MODE_SAMPLE, 10'd1023, '0, '0, '0);
    send_request(MODE_SAMPLE, 10'd600, '0, '0, '0);
    send_request(MODE_SAMPLE, 10'd300, '1, '1, '1);
    send_request(MODE_SAMPLE, 10'd450, '0, '0, '0);
    send_request(MODE_SAMPLE, 10'd301, '0, '0, '0);
    send_request(MODE_CHECK, '0, '0, '1, '1);
  endtask

  task automatic test_calibration();
    wait_idle();
    // zero span
    load_settings(512, 512, PAUSE_RESET, LIGHT_RESET, MOIST_RESET);
    send_request(MODE_SAMPLE, 10'd0, '0, '0, '0);
    send_request(MODE_SAMPLE, 10'd512, '0, '0, '0);
    send_request(MODE_SAMPLE, 10'd1023, '0, '0, '0);
    wait_idle();
    // reversed direction, full span
    load_settings(0, 1023, PAUSE_RESET, LIGHT_RESET, MOIST_RESET);
    send_request(MODE_SAMPLE, 10'd0, '0, '0, '0);
    send_request(MODE_SAMPLE, 10'd1023, '0, '0, '0);
    send_request(MODE_SAMPLE, 10'd511, '0, '0, '0);
    wait_idle();
    // all-ones write must be cut to the register width
    load_settings('1, 0, PAUSE_RESET, LIGHT_RESET, MOIST_RESET);
    send_request(MODE_SAMPLE, 10'd1023, '0, '0, '0);
    send_request(MODE_SAMPLE, 10'd0, '0, '0, '0);
    send_request(MODE_SAMPLE, 10'd700, '0, '0, '0);
  endtask

  task automatic test_register_limits();
    wait_idle();
    load_settings(600, 300, 0, 1023, 127);
    // writes past the last register change nothing
    for (int i = REG_SPARE_FIRST; i < 2 ** CFG_IDX_W; i++) begin
      write_reg(CFG_IDX_W'(i), '1);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    send_request(MODE_CHECK, '0, 10'd1022, last_watered, 16'h00FF);
    send_request(MODE_CHECK, '0, 10'd1022, last_watered + 1, 16'hA5A5);
    send_request(MODE_CHECK, '0, 10'd1023, last_watered + 5, 16'h5A5A);
    wait_idle();
    load_settings(600, 300, '1, 1023, 127);
    send_request(MODE_CHECK, '0, '0, last_watered - 1, 16'h0F0F);
    wait_idle();
    load_settings(600, 300, 0, 1023, 0);
    send_request(MODE_CHECK, '0, '0, last_watered + 9, 16'hF0F0);
    wait_idle();
    load_settings(600, 300, 0, 0, 127);
    send_request(MODE_CHECK, '0, '0, last_watered + 9, 16'h3C3C);
  endtask

  // time mostly moves forward at a pace near the pause so waterings happen
  task automatic test_random(int phases, int per_phase);
    logic [CFG_DATA_W-1:0] dry;
    logic [CFG_DATA_W-1:0] wet;
    logic [CFG_DATA_W-1:0] pause;
    logic [CFG_DATA_W-1:0] light_lim;
    logic [CFG_DATA_W-1:0] moist_lim;
    logic [CFG_DATA_W-1:0] step_max;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] moist;
    logic [SAMPLE_W-1:0] light;
    logic [TIME_W-1:0] now;
    for (int p = 0; p < phases; p++) begin
      wait_idle();
      dry = $urandom_range(1023);
      wet = $urandom_range(1023);
      case (p % 4)
        0: begin
          dry = 1023;
          wet = 0;
        end
        1: begin
          dry = 0;
          wet = 1023;
        end
        2: wet = dry;
        default: ;
      endcase
      case ($urandom_range(4))
        0: pause = 0;
        1: pause = $urandom_range(255);
        2: pause = $urandom_range(100000, 1000);
        3: pause = (p % 2) ? '1 : $urandom;
        default: pause = $urandom;
      endcase
      step_max = (pause > 32'h3FFF_FFFF) ? '1 : pause * 3 + 16;
      light_lim = (p == 0) ? 1023 : $urandom_range(1023);
      moist_lim = (p == 1) ? 100 : $urandom_range(127);
      load_settings(dry, wet, pause, light_lim, moist_lim);
      lo = (dry < wet) ? dry[SAMPLE_W-1:0] : wet[SAMPLE_W-1:0];
      hi = (dry < wet) ? wet[SAMPLE_W-1:0] : dry[SAMPLE_W-1:0];
      sim_ticks = last_watered;
      steady = (p == 3);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(99) < 55) begin
          moist = ($urandom_range(99) < 85) ? SAMPLE_W'($urandom_range(hi, lo))
                                            : SAMPLE_W'($urandom);
          send_request(MODE_SAMPLE, moist, SAMPLE_W'($urandom), $urandom,
                       PULSE_W'($urandom));
        end else begin
          sim_ticks = sim_ticks + $urandom_range(step_max, 0);
          light = (light_lim != 0 && $urandom_range(99) < 70)
                  ? SAMPLE_W'($urandom_range(light_lim - 1, 0)) : SAMPLE_W'($urandom);
          now = ($urandom_range(99) < 10) ? $urandom : sim_ticks;
          send_request(MODE_CHECK, SAMPLE_W'($urandom), light, now, PULSE_W'($urandom));
        end
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    dry_cal = DRY_RESET;
    wet_cal = WET_RESET;
    pause_min = PAUSE_RESET;
    light_max = LIGHT_RESET;
    moist_max = MOIST_RESET;
    for (int i = 0; i < WINDOW_DEPTH; i++) pct_hist[i] = '0;
    hist_ptr = 0;
    hist_sum = '0;
    last_watered = '0;
    water_tally = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_defaults();
    test_calibration();
    test_register_limits();
    test_random(7, 200);
    wait_idle();
    $display("Run covered %0d samples and %0d checks over %0d register settings,",
             n_samples, n_checks, n_settings);
    $display("with %0d waterings ordered and %0d mismatches.", n_watered, err_count);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results still pending", pending_decisions.size());
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== soil_moisture_watering_decider.f =====
+incdir+design
design/smwd_pkg.sv
design/smwd_ram.sv
design/smwd_div.sv
design/smwd_ctrl.sv
design/smwd_dp.sv
design/soil_moisture_watering_decider.sv
design/smwd_checker.sv
tb/soil_moisture_watering_decider_tb.sv
